FILE: rtl/vsa_pkg.sv
// ----------------------------------------------------------------------------
// vsa_pkg
// shared constants and codes for the variable segment allocator
// ----------------------------------------------------------------------------
package vsa_pkg;

    localparam int MAX_SEGS_DEF  = 32;
    localparam int ADDR_BITS_DEF = 16;

    localparam int OWNER_W = 16;
    localparam int WAIT_W  = 32;

    typedef logic [1:0] t_req;
    typedef logic [1:0] t_status;

    localparam t_req REQ_BEST = 2'd0;
    localparam t_req REQ_NEXT = 2'd1;
    localparam t_req REQ_FREE = 2'd2;

    localparam t_status ST_OK   = 2'd0;
    localparam t_status ST_FAIL = 2'd1;
    localparam t_status ST_FULL = 2'd2;

endpackage

FILE: rtl/vsa_seg_ram.sv
// ----------------------------------------------------------------------------
// vsa_seg_ram
// segment table memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module vsa_seg_ram #(
    parameter int DEPTH = vsa_pkg::MAX_SEGS_DEF,
    parameter int WIDTH = 81
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

FILE: rtl/variable_segment_allocator.sv
// ----------------------------------------------------------------------------
// variable_segment_allocator
// best-fit / next-fit segment allocator with coalescing free
//
//   channel | direction | transfer when
//   --------+-----------+-----------------------------
//   in      | input     | i_in_valid & o_in_ready
//   out     | output    | o_out_valid & i_out_ready
//   cfg     | input     | i_cfg_we (no handshake)
//
// one request at a time through a sequencer and one table memory port.
// best fit and free scan the table once and next fit twice; free then reads both neighbours;
// a split shifts later entries up to make room, a merge shifts them down over the merged ones.
// after reset or a mem_size write, the init state rebuilds the table before ready.
// a stalled result holds in the output register; ready returns once the next
// result has moved into the output register.
// ----------------------------------------------------------------------------
module variable_segment_allocator #(
    parameter int MAX_SEGS  = vsa_pkg::MAX_SEGS_DEF,
    parameter int ADDR_BITS = vsa_pkg::ADDR_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_req_type,
    input  logic [15:0] i_owner_id,
    input  logic [15:0] i_req_size,
    input  logic [31:0] i_wait_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [15:0] o_seg_addr,
    output logic [31:0] o_wait_out,
    output logic [15:0] o_free_total,
    output logic [5:0]  o_seg_count
);

    localparam int AW = ADDR_BITS;
    localparam int OW = vsa_pkg::OWNER_W;
    localparam int WW = vsa_pkg::WAIT_W;
    localparam int EW = 2 * AW + 1 + OW + WW;
    localparam int IW = $clog2(MAX_SEGS);
    localparam int CW = $clog2(MAX_SEGS + 1);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_BF_SCAN, S_NA_SCAN, S_NB_SETUP, S_NB_SCAN, S_FR_SCAN,
        S_PLACE_CHK, S_SH_RD, S_SH_WR, S_PL_WR_HI, S_PL_WR_LO,
        S_FR_PREV, S_FR_GPREV, S_FR_GNEXT, S_FR_WR
    } t_state;

    t_state r_state, r_after;
    logic   r_resp;

    logic [AW-1:0] r_mem_size, r_last, r_free, r_size, r_kstart;
    logic [AW-1:0] r_pstart, r_plen, r_nlen, r_addr;
    logic [CW-1:0] r_n, r_cur, r_j, r_t, r_k, r_si, r_lim;
    logic [1:0]    r_d;
    logic          r_up, r_found, r_pfree, r_nfree;
    vsa_pkg::t_req    r_type;
    vsa_pkg::t_status r_st;
    logic [OW-1:0] r_owner;
    logic [WW-1:0] r_wait, r_wout;
    logic [EW-1:0] r_ent;

    logic [EW-1:0] s_rd, s_wdata;
    logic [CW-1:0] s_raddr, s_waddr, s_nxt_cur, s_idx0;
    logic          s_we, s_last, s_hit, s_sh_done;

    logic          rd_used;
    logic [AW-1:0] rd_start, rd_len, ent_start, ent_len, bst_len, fr_len, wr_size;
    logic [OW-1:0] rd_owner;
    logic [WW-1:0] ent_wait;
    logic [AW-1:0] in_size;

    assign rd_used   = s_rd[EW-1];
    assign rd_start  = s_rd[EW-2 -: AW];
    assign rd_len    = s_rd[EW-2-AW -: AW];
    assign rd_owner  = s_rd[WW +: OW];
    assign ent_start = r_ent[EW-2 -: AW];
    assign ent_len   = r_ent[EW-2-AW -: AW];
    assign ent_wait  = r_ent[WW-1:0];
    assign bst_len   = ent_len;
    assign in_size   = AW'(i_req_size);

    assign s_last    = (r_j == CW'(r_n - 1'b1));
    assign s_nxt_cur = (CW'(r_cur + 1'b1) == r_n) ? '0 : CW'(r_cur + 1'b1);
    assign s_idx0    = (CW'(r_k + (r_kstart != r_last)) == r_n) ? '0
                     : CW'(r_k + (r_kstart != r_last));
    assign s_sh_done = r_up ? (r_si <= r_lim) : (r_si >= r_lim);
    assign fr_len    = AW'(ent_len + (r_nfree ? r_nlen : '0) + (r_pfree ? r_plen : '0));
    assign wr_size   = r_size;

    always_comb begin
        case (r_state)
            S_BF_SCAN: s_hit = !rd_used && rd_len >= r_size && (!r_found || rd_len < bst_len);
            S_NB_SCAN: s_hit = !r_found && !rd_used && rd_len >= r_size;
            S_FR_SCAN: s_hit = !r_found && rd_used && rd_owner == r_owner;
            default:   s_hit = 1'b0;
        endcase
    end

    always_comb begin
        case (r_state)
            S_BF_SCAN, S_NA_SCAN, S_NB_SCAN, S_FR_SCAN: s_raddr = s_nxt_cur;
            S_NB_SETUP: s_raddr = s_idx0;
            S_SH_RD:    s_raddr = r_up ? CW'(r_si - 1'b1) : CW'(r_si + r_d);
            S_FR_PREV:  s_raddr = CW'(r_t - 1'b1);
            S_FR_GPREV: s_raddr = CW'(r_t + 1'b1);
            default:    s_raddr = '0;
        endcase
    end

    always_comb begin
        s_we    = 1'b0;
        s_waddr = r_t;
        s_wdata = {1'b0, ent_start, ent_len, r_ent[WW +: OW], ent_wait};
        case (r_state)
            S_INIT: begin
                s_we    = 1'b1;
                s_waddr = '0;
                s_wdata = {1'b0, {AW{1'b0}}, r_mem_size, {OW{1'b0}}, {WW{1'b0}}};
            end
            S_SH_WR: begin
                s_we    = 1'b1;
                s_waddr = r_si;
                s_wdata = s_rd;
            end
            S_PL_WR_HI: begin
                s_we    = 1'b1;
                s_waddr = CW'(r_t + 1'b1);
                s_wdata = {1'b0, AW'(ent_start + wr_size), AW'(ent_len - wr_size),
                           {OW{1'b0}}, {WW{1'b0}}};
            end
            S_PL_WR_LO: begin
                s_we    = 1'b1;
                s_wdata = {1'b1, ent_start, wr_size, r_owner, r_wait};
            end
            S_FR_WR: begin
                s_we    = 1'b1;
                s_waddr = r_pfree ? CW'(r_t - 1'b1) : r_t;
                s_wdata = {1'b0, r_pfree ? r_pstart : ent_start, fr_len,
                           {OW{1'b0}}, {WW{1'b0}}};
            end
            default: begin
                s_we = 1'b0;
            end
        endcase
    end

    vsa_seg_ram #(
        .DEPTH (MAX_SEGS),
        .WIDTH (EW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr[IW-1:0]),
        .i_wdata (s_wdata),
        .i_raddr (s_raddr[IW-1:0]),
        .o_rdata (s_rd)
    );

    assign o_in_ready = (r_state == S_IDLE) && !r_resp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_after     <= S_IDLE;
            r_resp      <= 1'b0;
            r_mem_size  <= AW'(16'hFFFF);
            r_n         <= CW'(1);
            r_last      <= '0;
            r_free      <= AW'(16'hFFFF);
            o_out_valid <= 1'b0;
        end else begin
            if (r_resp && (!o_out_valid || i_out_ready)) begin
                o_out_valid  <= 1'b1;
                o_status     <= r_st;
                o_seg_addr   <= 16'(r_addr);
                o_wait_out   <= r_wout;
                o_free_total <= 16'(r_free);
                o_seg_count  <= 6'(r_n);
                r_resp       <= 1'b0;
            end else if (o_out_valid && i_out_ready) begin
                o_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_mem_size <= AW'(i_cfg_wdata);
                r_state    <= S_INIT;
            end else begin
                case (r_state)
                    S_INIT: begin
                        r_n     <= CW'(1);
                        r_last  <= '0;
                        r_free  <= r_mem_size;
                        r_state <= S_IDLE;
                    end
                    S_IDLE: begin
                        if (i_in_valid && o_in_ready) begin
                            r_type  <= i_req_type;
                            r_owner <= i_owner_id;
                            r_size  <= in_size;
                            r_wait  <= i_wait_in;
                            r_st    <= vsa_pkg::ST_FAIL;
                            r_addr  <= '0;
                            r_wout  <= '0;
                            r_found <= 1'b0;
                            r_cur   <= '0;
                            r_j     <= '0;
                            r_k     <= '0;
                            r_kstart <= '0;
                            if (i_req_type == vsa_pkg::REQ_BEST
                                    || i_req_type == vsa_pkg::REQ_NEXT) begin
                                if (in_size == '0 || r_free < in_size) begin
                                    r_resp <= 1'b1;
                                end else if (i_req_type == vsa_pkg::REQ_BEST) begin
                                    r_state <= S_BF_SCAN;
                                end else begin
                                    r_state <= S_NA_SCAN;
                                end
                            end else if (i_req_type == vsa_pkg::REQ_FREE) begin
                                r_state <= S_FR_SCAN;
                            end else begin
                                r_resp <= 1'b1;
                            end
                        end
                    end
                    S_BF_SCAN, S_NB_SCAN, S_FR_SCAN: begin
                        if (s_hit) begin
                            r_found <= 1'b1;
                            r_t     <= r_cur;
                            r_ent   <= s_rd;
                        end
                        r_cur <= s_nxt_cur;
                        r_j   <= CW'(r_j + 1'b1);
                        if (s_last) begin
                            if (!(r_found || s_hit)) begin
                                r_state <= S_IDLE;
                                r_resp  <= 1'b1;
                            end else if (r_state == S_FR_SCAN) begin
                                r_state <= S_FR_PREV;
                            end else begin
                                r_state <= S_PLACE_CHK;
                            end
                        end
                    end
                    S_NA_SCAN: begin
                        if (rd_start <= r_last) begin
                            r_k      <= r_cur;
                            r_kstart <= rd_start;
                        end
                        r_cur <= s_nxt_cur;
                        r_j   <= CW'(r_j + 1'b1);
                        if (s_last) begin
                            r_state <= S_NB_SETUP;
                        end
                    end
                    S_NB_SETUP: begin
                        r_cur   <= s_idx0;
                        r_j     <= '0;
                        r_state <= S_NB_SCAN;
                    end
                    S_PLACE_CHK: begin
                        if (ent_len > r_size) begin
                            if (r_n >= CW'(MAX_SEGS)) begin
                                r_st    <= vsa_pkg::ST_FULL;
                                r_resp  <= 1'b1;
                                r_state <= S_IDLE;
                            end else begin
                                r_up    <= 1'b1;
                                r_si    <= r_n;
                                r_lim   <= CW'(r_t + 1'b1);
                                r_after <= S_PL_WR_HI;
                                r_state <= S_SH_RD;
                            end
                        end else begin
                            r_state <= S_PL_WR_LO;
                        end
                    end
                    S_SH_RD: begin
                        if (s_sh_done) begin
                            r_state <= r_after;
                            if (r_after == S_IDLE) begin
                                r_resp <= 1'b1;
                            end
                        end else begin
                            r_state <= S_SH_WR;
                        end
                    end
                    S_SH_WR: begin
                        r_si    <= r_up ? CW'(r_si - 1'b1) : CW'(r_si + 1'b1);
                        r_state <= S_SH_RD;
                    end
                    S_PL_WR_HI: begin
                        r_n     <= CW'(r_n + 1'b1);
                        r_state <= S_PL_WR_LO;
                    end
                    S_PL_WR_LO: begin
                        r_free <= AW'(r_free - r_size);
                        r_st   <= vsa_pkg::ST_OK;
                        r_addr <= ent_start;
                        if (r_type == vsa_pkg::REQ_NEXT) begin
                            r_last <= ent_start;
                        end
                        r_resp  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                    S_FR_PREV: begin
                        r_state <= S_FR_GPREV;
                    end
                    S_FR_GPREV: begin
                        r_pfree  <= (r_t != '0) && !rd_used;
                        r_pstart <= rd_start;
                        r_plen   <= rd_len;
                        r_state  <= S_FR_GNEXT;
                    end
                    S_FR_GNEXT: begin
                        r_nfree <= (CW'(r_t + 1'b1) < r_n) && !rd_used;
                        r_nlen  <= rd_len;
                        r_state <= S_FR_WR;
                    end
                    S_FR_WR: begin
                        r_free  <= AW'(r_free + ent_len);
                        r_st    <= vsa_pkg::ST_OK;
                        r_addr  <= ent_start;
                        r_wout  <= ent_wait;
                        r_up    <= 1'b0;
                        r_after <= S_IDLE;
                        if (r_pfree && r_nfree) begin
                            r_si    <= r_t;
                            r_d     <= 2'd2;
                            r_lim   <= CW'(r_n - 2'd2);
                            r_n     <= CW'(r_n - 2'd2);
                            r_state <= S_SH_RD;
                        end else if (r_pfree) begin
                            r_si    <= r_t;
                            r_d     <= 2'd1;
                            r_lim   <= CW'(r_n - 1'b1);
                            r_n     <= CW'(r_n - 1'b1);
                            r_state <= S_SH_RD;
                        end else if (r_nfree) begin
                            r_si    <= CW'(r_t + 1'b1);
                            r_d     <= 2'd1;
                            r_lim   <= CW'(r_n - 1'b1);
                            r_n     <= CW'(r_n - 1'b1);
                            r_state <= S_SH_RD;
                        end else begin
                            r_resp  <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    end
                    default: begin
                        r_state <= S_IDLE;
                    end
                endcase
            end
        end
    end

endmodule

FILE: rtl/vsa_checker.sv
// ----------------------------------------------------------------------------
// vsa_checker
// port-level checks for the variable segment allocator
// ----------------------------------------------------------------------------
module vsa_checker #(
    parameter int MAX_SEGS = vsa_pkg::MAX_SEGS_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_status,
    input logic [15:0] o_seg_addr,
    input logic [31:0] o_wait_out,
    input logic [5:0]  o_seg_count
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
            && $stable(o_seg_addr) && $stable(o_wait_out))
        else $error("result changed while stalled");

    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready right after a request transfer");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != vsa_pkg::ST_OK |-> o_seg_addr == 16'd0
            && o_wait_out == 32'd0)
        else $error("failed request reports nonzero address or wait");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_seg_count != 6'd0 && 32'(o_seg_count) <= MAX_SEGS)
        else $error("segment count out of range");

endmodule

bind variable_segment_allocator vsa_checker #(.MAX_SEGS(MAX_SEGS)) u_vsa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_status    (o_status),
    .o_seg_addr  (o_seg_addr),
    .o_wait_out  (o_wait_out),
    .o_seg_count (o_seg_count)
);
